[hw/rtl/csvc_pkg.sv]
// ----------------------------------------------------------------------------
// csvc_pkg
// Shared types and constants of the credit-shaped virtual-clock scheduler.
// ----------------------------------------------------------------------------
package csvc_pkg;

   localparam int FLOW_COUNT_DEF     = 16;
   localparam int PER_FLOW_DEPTH_DEF = 64;

   localparam int CREDIT_W = 40;
   localparam int STAMP_W  = 32;
   localparam int QUEUED_W = 24;
   localparam int FREE_W   = 25;
   localparam int BYTES_W  = 16;
   localparam int DESC_W   = 16;
   localparam int CSR_W    = 24;
   localparam int QUEUE_W  = 2;

   localparam logic [23:0] BUFFER_BYTES_RST = 24'd1048576;
   localparam logic [7:0]  ADMIT_FACTOR_RST = 8'd14;
   localparam logic [15:0] CREDIT_RATE_RST  = 16'd105;

   localparam logic [1:0] CSR_BUFFER_BYTES = 2'd0;
   localparam logic [1:0] CSR_ADMIT_FACTOR = 2'd1;
   localparam logic [1:0] CSR_CREDIT_RATE  = 2'd2;

   localparam logic [1:0] OUT_ACCEPTED = 2'd0;
   localparam logic [1:0] OUT_DROPPED  = 2'd1;
   localparam logic [1:0] OUT_DEQUEUED = 2'd2;
   localparam logic [1:0] OUT_NONE     = 2'd3;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // One accepted command as it travels from the front end to the back end.
   typedef struct packed {
      logic        opcode;
      logic [7:0]  flow;
      logic        flow_ok;
      logic [15:0] bytes;
      logic [15:0] desc;
      logic [31:0] now;
   } cmd_type;

endpackage

[hw/rtl/credit_shaped_virtual_clock_scheduler.sv]
// An enqueue passes the command queue, ST_IDLE and ST_ENQ before rsp_valid; a dequeue passes
// the command queue, ST_IDLE, ST_GAIN, a credit pass and a scan pass over all flows, ST_READ,
// and then ST_WAIT and ST_SERVE unless none is eligible. The back end takes a new command
// only in ST_IDLE; the queue holds two more commands and busy rises while it is full.
// Reset: synchronous and active high; clears all queues, credits and stamps.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// credit_shaped_virtual_clock_scheduler
// Per-flow descriptor queues with shared-buffer admission and credit-gated pick.
// ----------------------------------------------------------------------------
module credit_shaped_virtual_clock_scheduler #(
   parameter int FLOW_COUNT     = csvc_pkg::FLOW_COUNT_DEF,
   parameter int PER_FLOW_DEPTH = csvc_pkg::PER_FLOW_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [3:0]  req_flow_index,
   input  logic [15:0] req_packet_bytes,
   input  logic [15:0] req_descriptor,
   input  logic [31:0] req_now_ticks,
   output logic        rsp_valid,
   output logic [1:0]  rsp_outcome,
   output logic [3:0]  rsp_out_flow,
   output logic [15:0] rsp_out_descriptor,
   output logic [15:0] rsp_out_bytes,
   output logic [23:0] rsp_queued_total,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wr_data
);

   logic [7:0]        admit_factor_ff;
   logic [15:0]       credit_rate_ff;
   logic              cmd_valid, cmd_pop, buffer_wr;
   csvc_pkg::cmd_type cmd_data;

   assign buffer_wr = csr_wr_en && (csr_index == csvc_pkg::CSR_BUFFER_BYTES);

   always_ff @(posedge clock) begin
      if (reset) begin
         admit_factor_ff <= csvc_pkg::ADMIT_FACTOR_RST;
         credit_rate_ff  <= csvc_pkg::CREDIT_RATE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            // The buffer size only sets the free byte count in the back end.
            csvc_pkg::CSR_BUFFER_BYTES: ;
            csvc_pkg::CSR_ADMIT_FACTOR: admit_factor_ff <= csr_wr_data[7:0];
            csvc_pkg::CSR_CREDIT_RATE:  credit_rate_ff  <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   csvc_front #(.FLOW_COUNT(FLOW_COUNT)) u_front (
      .clock, .reset, .start, .busy,
      .req_opcode, .req_flow_index, .req_packet_bytes, .req_descriptor,
      .req_now_ticks, .cmd_valid, .cmd_data, .cmd_pop
   );

   csvc_back #(.FLOW_COUNT(FLOW_COUNT), .PER_FLOW_DEPTH(PER_FLOW_DEPTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_pop,
      .buffer_bytes (csr_wr_data),
      .buffer_wr,
      .admit_factor (admit_factor_ff),
      .credit_rate  (credit_rate_ff),
      .rsp_valid, .rsp_outcome, .rsp_out_flow, .rsp_out_descriptor,
      .rsp_out_bytes, .rsp_queued_total
   );

`ifndef ASSERT_OFF
   // A served packet always reports a flow below the flow count.
   a_flow_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == csvc_pkg::OUT_DEQUEUED |->
      32'(rsp_out_flow) < 32'(FLOW_COUNT)) else $error("served flow out of range");
   // Results other than dequeues never carry a descriptor.
   a_desc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != csvc_pkg::OUT_DEQUEUED |->
      rsp_out_descriptor == '0) else $error("descriptor on non-dequeue");
   // The command queue never pops while empty.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("pop from empty queue");
`endif

endmodule

[hw/rtl/csvc_ram.sv]
// ----------------------------------------------------------------------------
// csvc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/csvc_front.sv]
// ----------------------------------------------------------------------------
// csvc_front
// Command front end: takes start transfers and queues them for the back end.
// ----------------------------------------------------------------------------
module csvc_front #(
   parameter int FLOW_COUNT = csvc_pkg::FLOW_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_opcode,
   input  logic [3:0]        req_flow_index,
   input  logic [15:0]       req_packet_bytes,
   input  logic [15:0]       req_descriptor,
   input  logic [31:0]       req_now_ticks,
   output logic              cmd_valid,
   output csvc_pkg::cmd_type cmd_data,
   input  logic              cmd_pop
);

   localparam int QD = csvc_pkg::QUEUE_W;

   csvc_pkg::cmd_type q_ff [QD];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;
   csvc_pkg::cmd_type cmd_new;

   assign busy = (cnt_ff == 2'(QD));
   assign push = start && !busy;

   always_comb begin
      cmd_new         = '0;
      cmd_new.opcode  = req_opcode;
      cmd_new.flow    = 8'(req_flow_index);
      cmd_new.flow_ok = (32'(req_flow_index) < 32'(FLOW_COUNT));
      cmd_new.bytes   = req_packet_bytes;
      cmd_new.desc    = req_descriptor;
      cmd_new.now     = req_now_ticks;
   end

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = cmd_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= cmd_new;
      end
   end

   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rp_ff];

endmodule

[hw/rtl/csvc_back.sv]
// ----------------------------------------------------------------------------
// csvc_back
// Scheduler back end: admission, credit update, flow pick and FIFO access.
// ----------------------------------------------------------------------------
module csvc_back #(
   parameter int FLOW_COUNT     = csvc_pkg::FLOW_COUNT_DEF,
   parameter int PER_FLOW_DEPTH = csvc_pkg::PER_FLOW_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  csvc_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   input  logic [23:0]       buffer_bytes,
   input  logic              buffer_wr,
   input  logic [7:0]        admit_factor,
   input  logic [15:0]       credit_rate,
   output logic              rsp_valid,
   output logic [1:0]        rsp_outcome,
   output logic [3:0]        rsp_out_flow,
   output logic [15:0]       rsp_out_descriptor,
   output logic [15:0]       rsp_out_bytes,
   output logic [23:0]       rsp_queued_total
);

   localparam int FW = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
   localparam int PW = $clog2(PER_FLOW_DEPTH);
   localparam int CW = $clog2(PER_FLOW_DEPTH + 1);
   localparam int AW = FW + PW;
   localparam logic signed [39:0] CMAX = {1'b0, {39{1'b1}}};
   localparam logic signed [39:0] CMIN = {1'b1, {39{1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_GAIN, ST_CREDIT, ST_SCAN, ST_READ, ST_WAIT, ST_SERVE, ST_ENQ
   } state_type;

   state_type         state_ff;
   csvc_pkg::cmd_type cmd_ff;
   logic [PW-1:0]     head_ff [FLOW_COUNT];
   logic [PW-1:0]     tail_ff [FLOW_COUNT];
   logic [CW-1:0]     fill_ff [FLOW_COUNT];
   logic signed [39:0] credit_ff [FLOW_COUNT];
   logic [31:0]       stamp_ff [FLOW_COUNT];
   logic [23:0]       queued_ff;
   logic signed [24:0] free_ff;
   logic [31:0]       last_ff;
   logic [47:0]       gain_ff;
   logic signed [33:0] limit_ff;
   logic [FW-1:0]     idx_ff;
   logic [FW-1:0]     pick_ff;
   logic              found_ff;

   logic              ram_we;
   logic [AW-1:0]     ram_wa, ram_ra;
   logic [31:0]       ram_rd;

   logic              rv_ff;
   logic [1:0]        ro_ff;
   logic [3:0]        rf_ff;
   logic [15:0]       rdsc_ff, rb_ff;
   logic [23:0]       rq_ff;

   logic [FW-1:0]     cflow;
   logic              full, ovf, admit;
   logic [24:0]       qsum;
   logic              elig, better;

   assign cflow = cmd_ff.flow[FW-1:0];
   assign qsum  = {1'b0, queued_ff} + 25'(cmd_ff.bytes);
   assign full  = (32'(fill_ff[cflow]) >= 32'(PER_FLOW_DEPTH));
   assign ovf   = qsum[24];
   // limit_ff holds admit_factor times free bytes, registered in ST_IDLE when the command is taken.
   assign admit = cmd_ff.flow_ok && !full && !ovf &&
                  !($signed({10'd0, queued_ff}) > limit_ff);
   assign elig  = (fill_ff[idx_ff] != '0) && !credit_ff[idx_ff][39];
   assign better = !found_ff || (stamp_ff[idx_ff] < stamp_ff[pick_ff]);

   assign ram_we = (state_ff == ST_ENQ) && admit;
   assign ram_wa = {cflow, tail_ff[cflow]};
   assign ram_ra = {pick_ff, head_ff[pick_ff]};

   csvc_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data ({cmd_ff.bytes, cmd_ff.desc}),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   function automatic logic signed [39:0] sat_add(input logic signed [39:0] a,
                                                 input logic signed [48:0] b);
      logic signed [49:0] s;
      begin
         s = 50'(a) + 50'(b);
         if (s > 50'(CMAX)) sat_add = CMAX;
         else if (s < 50'(CMIN)) sat_add = CMIN;
         else sat_add = s[39:0];
      end
   endfunction

   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;

   always_ff @(posedge clock) begin
      logic [15:0] pb;
      logic signed [39:0] cb;
      logic [31:0] elapsed;
      rv_ff <= 1'b0;
      if (reset) begin
         state_ff  <= ST_IDLE;
         queued_ff <= '0;
         free_ff   <= 25'(csvc_pkg::BUFFER_BYTES_RST);
         last_ff   <= '0;
         for (int i = 0; i < FLOW_COUNT; i++) begin
            head_ff[i]   <= '0;
            tail_ff[i]   <= '0;
            fill_ff[i]   <= '0;
            credit_ff[i] <= '0;
            stamp_ff[i]  <= '0;
         end
      end else begin
         if (buffer_wr) begin
            free_ff <= $signed({1'b0, buffer_bytes}) - $signed({1'b0, queued_ff});
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd_data;
                  limit_ff <= $signed({1'b0, admit_factor}) * free_ff;
                  state_ff <= (cmd_data.opcode == csvc_pkg::OP_DEQUEUE) ? ST_GAIN : ST_ENQ;
               end
            end
            ST_ENQ: begin
               rv_ff   <= 1'b1;
               rf_ff   <= cmd_ff.flow[3:0];
               rdsc_ff <= '0;
               rb_ff   <= cmd_ff.bytes;
               if (admit) begin
                  tail_ff[cflow] <= (32'(tail_ff[cflow]) + 1 >= 32'(PER_FLOW_DEPTH))
                                    ? '0 : tail_ff[cflow] + 1'b1;
                  fill_ff[cflow] <= fill_ff[cflow] + 1'b1;
                  queued_ff <= qsum[23:0];
                  free_ff   <= free_ff - 25'(cmd_ff.bytes);
                  if (stamp_ff[cflow] < cmd_ff.now) stamp_ff[cflow] <= cmd_ff.now;
                  ro_ff <= csvc_pkg::OUT_ACCEPTED;
                  rq_ff <= qsum[23:0];
               end else begin
                  ro_ff <= csvc_pkg::OUT_DROPPED;
                  rq_ff <= queued_ff;
               end
               state_ff <= ST_IDLE;
            end
            ST_GAIN: begin
               // Elapsed time wraps at 32 bits before it is scaled.
               elapsed  = cmd_ff.now - last_ff;
               gain_ff  <= elapsed * credit_rate;
               last_ff  <= cmd_ff.now;
               idx_ff   <= '0;
               state_ff <= ST_CREDIT;
            end
            ST_CREDIT: begin
               // One flow's credit is topped up per cycle.
               credit_ff[idx_ff] <= sat_add(credit_ff[idx_ff], $signed({1'b0, gain_ff}));
               if (32'(idx_ff) == FLOW_COUNT - 1) begin
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  pick_ff  <= '0;
                  state_ff <= ST_SCAN;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_SCAN: begin
               if (elig && better) begin
                  pick_ff  <= idx_ff;
                  found_ff <= 1'b1;
               end
               if (32'(idx_ff) == FLOW_COUNT - 1) begin
                  state_ff <= ST_READ;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_READ: begin
               if (found_ff) begin
                  state_ff <= ST_WAIT;
               end else begin
                  rv_ff    <= 1'b1;
                  ro_ff    <= csvc_pkg::OUT_NONE;
                  rf_ff    <= '0;
                  rdsc_ff  <= '0;
                  rb_ff    <= '0;
                  rq_ff    <= queued_ff;
                  state_ff <= ST_IDLE;
               end
            end
            ST_WAIT: begin
               state_ff <= ST_SERVE;
            end
            ST_SERVE: begin
               pb = ram_rd[31:16];
               cb = (fill_ff[pick_ff] == CW'(1)) ? 40'sd0 : credit_ff[pick_ff];
               head_ff[pick_ff] <= (32'(head_ff[pick_ff]) + 1 >= 32'(PER_FLOW_DEPTH))
                                   ? '0 : head_ff[pick_ff] + 1'b1;
               fill_ff[pick_ff]   <= fill_ff[pick_ff] - 1'b1;
               credit_ff[pick_ff] <= sat_add(cb, -$signed({33'd0, pb}));
               queued_ff <= (queued_ff >= 24'(pb)) ? queued_ff - 24'(pb) : '0;
               free_ff   <= free_ff + 25'(pb);
               rv_ff   <= 1'b1;
               ro_ff   <= csvc_pkg::OUT_DEQUEUED;
               rf_ff   <= 4'(pick_ff);
               rdsc_ff <= ram_rd[15:0];
               rb_ff   <= pb;
               rq_ff   <= (queued_ff >= 24'(pb)) ? queued_ff - 24'(pb) : '0;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_outcome        = ro_ff;
   assign rsp_out_flow       = rf_ff;
   assign rsp_out_descriptor = rdsc_ff;
   assign rsp_out_bytes      = rb_ff;
   assign rsp_queued_total   = rq_ff;

endmodule

[tb/sv/credit_shaped_virtual_clock_scheduler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// credit_shaped_virtual_clock_scheduler_tb
// Drives enqueue and dequeue commands into the scheduler, predicts each result
// with a behavioral copy of the queues, credits and stamps, and checks every
// strobed result field by field. Buffer size, admission factor and credit
// rate are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module credit_shaped_virtual_clock_scheduler_tb;

   localparam int NFLOW = csvc_pkg::FLOW_COUNT_DEF;
   localparam int DEPTH = csvc_pkg::PER_FLOW_DEPTH_DEF;
   localparam longint CMAX = 64'sd549755813887;
   localparam longint CMIN = -CMAX - 1;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [3:0]  flow;
      logic [15:0] desc;
      logic [15:0] bytes;
      logic [23:0] queued;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_opcode = csvc_pkg::OP_ENQUEUE;
   logic [3:0]  req_flow_index = '0;
   logic [15:0] req_packet_bytes = '0;
   logic [15:0] req_descriptor = '0;
   logic [31:0] req_now_ticks = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_outcome;
   logic [3:0]  rsp_out_flow;
   logic [15:0] rsp_out_descriptor;
   logic [15:0] rsp_out_bytes;
   logic [23:0] rsp_queued_total;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_wr_data = '0;

   // Predictor state.
   logic [15:0] fifo_bytes [NFLOW][DEPTH];
   logic [15:0] fifo_desc  [NFLOW][DEPTH];
   int          head [NFLOW];
   int          tail [NFLOW];
   int          fill [NFLOW];
   longint      credit [NFLOW];
   logic [31:0] stamp [NFLOW];
   logic [23:0] queued_bytes;
   longint      free_bytes;
   logic [31:0] last_service;
   logic [7:0]  cfg_admit;
   logic [15:0] cfg_rate;

   sched_result_type expected_q [$];
   logic [31:0]   now_clock;
   int            mismatches;
   int            idle_cycles;
   bit            sender_gaps;
   bit            timed_out;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   credit_shaped_virtual_clock_scheduler u_top (.*);

   function automatic longint clamp40(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
   endfunction

   function automatic sched_result_type predict_step(logic op, logic [3:0] flow,
         logic [15:0] nbytes, logic [15:0] desc, logic [31:0] now);
      sched_result_type r;
      logic [31:0]   elapsed;
      longint        gain;
      int            pick;
      bit            ok;
      r = '0;
      if (op == csvc_pkg::OP_ENQUEUE) begin
         ok = (fill[flow] < DEPTH)
              && (longint'(queued_bytes) + longint'(nbytes) <= 64'hFFFFFF)
              && !(longint'(queued_bytes) > longint'(cfg_admit) * free_bytes);
         r.flow = flow;
         r.bytes = nbytes;
         if (ok) begin
            fifo_bytes[flow][tail[flow]] = nbytes;
            fifo_desc[flow][tail[flow]] = desc;
            tail[flow] = (tail[flow] + 1) % DEPTH;
            fill[flow]++;
            queued_bytes += nbytes;
            free_bytes -= longint'(nbytes);
            if (stamp[flow] < now) stamp[flow] = now;
            r.outcome = csvc_pkg::OUT_ACCEPTED;
         end else begin
            r.outcome = csvc_pkg::OUT_DROPPED;
         end
      end else begin
         elapsed = now - last_service;
         gain = longint'(elapsed) * longint'(cfg_rate);
         last_service = now;
         pick = -1;
         for (int f = 0; f < NFLOW; f++) credit[f] = clamp40(credit[f] + gain);
         for (int f = 0; f < NFLOW; f++) begin
            if (fill[f] == 0 || credit[f] < 0) continue;
            if (pick < 0 || stamp[f] < stamp[pick]) pick = f;
         end
         if (pick < 0) begin
            r.outcome = csvc_pkg::OUT_NONE;
         end else begin
            r.outcome = csvc_pkg::OUT_DEQUEUED;
            r.flow = pick[3:0];
            r.desc = fifo_desc[pick][head[pick]];
            r.bytes = fifo_bytes[pick][head[pick]];
            head[pick] = (head[pick] + 1) % DEPTH;
            fill[pick]--;
            if (fill[pick] == 0) credit[pick] = 0;
            credit[pick] = clamp40(credit[pick] - longint'(r.bytes));
            queued_bytes = (queued_bytes >= r.bytes) ? queued_bytes - r.bytes : 24'd0;
            free_bytes += longint'(r.bytes);
         end
      end
      r.queued = queued_bytes;
      return r;
   endfunction

   // Start stays high from one transfer to the next unless a gap is inserted.
   task automatic send_cmd(logic op, logic [3:0] flow, logic [15:0] nbytes,
         logic [15:0] desc, logic [31:0] now);
      int gap;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_flow_index <= flow;
      req_packet_bytes <= nbytes;
      req_descriptor <= desc;
      req_now_ticks <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_q.push_back(predict_step(op, flow, nbytes, desc, now));
   endtask

   task automatic enqueue(logic [3:0] flow, logic [15:0] nbytes, logic [15:0] desc);
      send_cmd(csvc_pkg::OP_ENQUEUE, flow, nbytes, desc, now_clock);
   endtask

   // Time moves forward by the given step and wraps at 32 bits.
   task automatic dequeue(logic [31:0] step);
      now_clock += step;
      send_cmd(csvc_pkg::OP_DEQUEUE, 4'($urandom_range(0, 15)), 16'($urandom),
               16'($urandom), now_clock);
   endtask

   task automatic drain_expected();
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (2 * NFLOW + 12) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] value);
      drain_expected();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == csvc_pkg::CSR_BUFFER_BYTES) begin
         free_bytes = longint'(value) - longint'(queued_bytes);
      end else if (idx == csvc_pkg::CSR_ADMIT_FACTOR) begin
         cfg_admit = value[7:0];
      end else begin
         cfg_rate = value[15:0];
      end
   endtask

   task automatic random_mix(int count, int deq_pct, int max_bytes, int max_step);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < deq_pct)
            dequeue($urandom_range(0, max_step));
         else
            enqueue(4'($urandom_range(0, 15)), 16'($urandom_range(0, max_bytes)),
                    16'($urandom));
      end
   endtask

   task automatic test_directed();
      enqueue(4'd0, 16'd0, 16'h0000);
      enqueue(4'd15, 16'hFFFF, 16'hFFFF);
      enqueue(4'd7, 16'd100, 16'hA5A5);
      dequeue(32'd0);
      dequeue(32'd0);
      dequeue(32'd1000);
      dequeue(32'd1000);
      // Nothing eligible with empty queues still updates time.
      dequeue(32'd5);
      // Equal stamps: lowest flow wins.
      enqueue(4'd9, 16'd10, 16'h1111);
      enqueue(4'd3, 16'd20, 16'h2222);
      dequeue(32'd0);
      dequeue(32'd0);
      // Fill one flow past its depth so the last ones drop.
      for (int i = 0; i < DEPTH + 2; i++) enqueue(4'd5, 16'd1, i[15:0]);
      for (int i = 0; i < DEPTH + 2; i++) dequeue(32'd1);
   endtask

   task automatic test_admission();
      // A zero buffer size and admission factor drive free bytes negative and admission drops.
      write_csr(csvc_pkg::CSR_BUFFER_BYTES, 24'd0);
      write_csr(csvc_pkg::CSR_ADMIT_FACTOR, 24'd0);
      enqueue(4'd1, 16'd50, 16'h0001);
      enqueue(4'd1, 16'd50, 16'h0002);
      random_mix(40, 40, 300, 20);
      write_csr(csvc_pkg::CSR_ADMIT_FACTOR, 24'd255);
      write_csr(csvc_pkg::CSR_BUFFER_BYTES, 24'd1000);
      random_mix(50, 40, 300, 20);
      write_csr(csvc_pkg::CSR_BUFFER_BYTES, 24'hFFFFFF);
      write_csr(csvc_pkg::CSR_ADMIT_FACTOR, 24'd14);
   endtask

   task automatic test_overflow();
      // Push the byte total up to the 24-bit ceiling with large packets.
      write_csr(csvc_pkg::CSR_ADMIT_FACTOR, 24'd255);
      for (int i = 0; i < 270; i++) enqueue(i[3:0], 16'hFFFF, 16'($urandom));
      for (int i = 0; i < 110; i++) dequeue(32'd100000);
   endtask

   task automatic test_credit_rates();
      write_csr(csvc_pkg::CSR_CREDIT_RATE, 24'd0);
      random_mix(50, 50, 2000, 50);
      write_csr(csvc_pkg::CSR_CREDIT_RATE, 24'd65535);
      random_mix(40, 50, 65535, 3);
      // Huge elapsed time saturates credit; wrapping time exercises modulo.
      dequeue(32'hFFFF_FFF0);
      dequeue(32'h40);
      write_csr(csvc_pkg::CSR_CREDIT_RATE, 24'd3);
   endtask

   task automatic test_random();
      sender_gaps = 1'b1;
      random_mix(100, 45, 1500, 200);
      drain_expected();
      random_mix(70, 50, 65535, 2000);
      sender_gaps = 1'b0;
      random_mix(70, 50, 800, 100);
   endtask

   // Results cannot be held off, so every strobe is checked at once.
   always @(posedge clock) begin
      sched_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: result with none expected");
         end else begin
            exp_r = expected_q.pop_front();
            if (exp_r != {rsp_outcome, rsp_out_flow, rsp_out_descriptor,
                          rsp_out_bytes, rsp_queued_total}) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: expected o=%0d f=%0d d=%h b=%0d q=%0d",
                     exp_r.outcome, exp_r.flow, exp_r.desc, exp_r.bytes, exp_r.queued);
                  $display("       got      o=%0d f=%0d d=%h b=%0d q=%0d",
                     rsp_outcome, rsp_out_flow, rsp_out_descriptor, rsp_out_bytes,
                     rsp_queued_total);
               end
            end
         end
      end
   end

   // A watchdog on cycles with no transfer on either side.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || csr_wr_en) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      mismatches = 0;
      idle_cycles = 0;
      timed_out = 1'b0;
      sender_gaps = 1'b0;
      now_clock = '0;
      queued_bytes = '0;
      last_service = '0;
      cfg_admit = csvc_pkg::ADMIT_FACTOR_RST;
      cfg_rate = csvc_pkg::CREDIT_RATE_RST;
      free_bytes = longint'(csvc_pkg::BUFFER_BYTES_RST);
      for (int f = 0; f < NFLOW; f++) begin
         head[f] = 0;
         tail[f] = 0;
         fill[f] = 0;
         credit[f] = 0;
         stamp[f] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_admission();
      test_credit_rates();
      test_overflow();
      test_random();
      drain_expected();
      if (mismatches == 0 && expected_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
